FILE: hw/rtl/rtb_pkg.sv
package rtb_pkg;

	localparam logic [1:0] MODE_ARM    = 2'd0;
	localparam logic [1:0] MODE_DISARM = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam int MAX_SLOTS = 8;

	typedef struct packed {
		logic [31:0] remaining;
		logic [31:0] reload;
		logic [15:0] repeats;
		logic [15:0] event_code;
	} slot_entry_t;

endpackage

FILE: hw/rtl/rtb_ram.sv
module rtb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/repeating_timer_bank_core.sv
// Repeating timer bank.
// Input channel (in_valid/in_ready) takes one item: arm, disarm or tick step.
// Output channel (out_valid/out_ready) returns result items; last_of_run marks
// the final result of each input item.
// Arm and disarm: one acknowledge item, shown the cycle after acceptance.
// Tick step: the slot table in RAM is scanned in index order, one slot read per
// cycle unless a firing slot waits on a full output register; the update is
// written back as the read slot moves on. Each firing slot gives a fire item,
// then a done item closes the tick; the single RAM read port paces the scan.
// A new item is taken only when the scan is finished and the output register
// is free or being emptied, so one item is at work at a time.
// A stalled receiver holds the output register; the scan waits on a firing
// slot until the register frees, non-firing slots keep moving.
// Reset clears all active flags and the output register; RAM contents are
// written by arm before any use.
module repeating_timer_bank_core #(
	parameter int NUM_TIMERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  timer_index,
	input  logic [31:0] load_ticks,
	input  logic [15:0] repeat_count,
	input  logic [15:0] event_code,
	input  logic [31:0] elapsed_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  fired_index,
	output logic [15:0] fired_event,
	output logic        last_of_run
);

	import rtb_pkg::*;

	localparam int SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int EW    = $bits(slot_entry_t);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [SLOTS-1:0]  active_q;
	logic [CW-1:0]     rd_cnt_q;
	logic [31:0]       elapsed_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [2:0]        idx_q;
	logic [15:0]       event_q;
	logic              last_q;

	slot_entry_t       rd_entry;
	slot_entry_t       wr_entry;
	logic [EW-1:0]     rd_word;
	logic              we;
	logic [AW-1:0]     waddr;

	logic              can_emit;
	logic              accept;
	logic              in_range;
	logic              s1_active;
	logic              hit_s1;
	logic              adv;
	logic              issue;
	logic              done_go;
	logic              s1_write;
	logic              arm_write;
	logic              s1_stop;

	assign can_emit  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && can_emit;
	assign accept    = in_valid && in_ready;
	assign in_range  = (4'(timer_index) < 4'(SLOTS));

	assign rd_entry  = slot_entry_t'(rd_word);
	assign s1_active = vld_s1 && active_q[idx_s1];
	assign hit_s1    = s1_active && (elapsed_q >= rd_entry.remaining);
	assign adv       = !hit_s1 || can_emit;
	assign issue     = (state_q == ST_SCAN) && adv && (rd_cnt_q < CW'(SLOTS));
	assign done_go   = (state_q == ST_SCAN) && !vld_s1 && (rd_cnt_q == CW'(SLOTS))
			&& can_emit;
	assign s1_write  = (state_q == ST_SCAN) && s1_active && adv;
	assign arm_write = accept && (mode == MODE_ARM) && in_range;
	assign s1_stop   = hit_s1 && (rd_entry.repeats == 16'd1);

	always_comb begin
		wr_entry = rd_entry;
		waddr    = idx_s1;
		if (arm_write) begin
			waddr               = timer_index[AW-1:0];
			wr_entry.remaining  = load_ticks;
			wr_entry.reload     = load_ticks;
			wr_entry.repeats    = repeat_count;
			wr_entry.event_code = event_code;
		end else if (hit_s1) begin
			wr_entry.remaining = rd_entry.reload;
			if (rd_entry.repeats != 16'd0) begin
				wr_entry.repeats = rd_entry.repeats - 16'd1;
			end
		end else begin
			wr_entry.remaining = rd_entry.remaining - elapsed_q;
		end
	end

	assign we = arm_write || s1_write;

	rtb_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.re   (issue),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= '0;
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (arm_write) begin
				active_q[timer_index[AW-1:0]] <= 1'b1;
			end else if (accept && (mode == MODE_DISARM) && in_range) begin
				active_q[timer_index[AW-1:0]] <= 1'b0;
			end else if (s1_write && s1_stop) begin
				active_q[idx_s1] <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_TICK)) begin
						state_q  <= ST_SCAN;
						rd_cnt_q <= '0;
						vld_s1   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						vld_s1 <= issue;
					end
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_TICK)) begin
			elapsed_q <= elapsed_ticks;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hit_s1 && adv) begin
			out_valid_q <= 1'b1;
		end else if (done_go) begin
			out_valid_q <= 1'b1;
		end else if (accept && (mode != MODE_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_s1 && adv) begin
			kind_q  <= KIND_FIRE;
			idx_q   <= 3'(idx_s1);
			event_q <= rd_entry.event_code;
			last_q  <= 1'b0;
		end else if (done_go) begin
			kind_q  <= KIND_DONE;
			idx_q   <= 3'd0;
			event_q <= 16'd0;
			last_q  <= 1'b1;
		end else if (accept && (mode != MODE_TICK)) begin
			kind_q  <= KIND_ACK;
			idx_q   <= 3'd0;
			event_q <= 16'd0;
			last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign fired_index = idx_q;
	assign fired_event = event_q;
	assign last_of_run = last_q;

endmodule
